FILE: design/circular_deque_unit_defines.svh
// ---------------------------------------------------------------------------
// circular_deque_unit_defines.svh
// Assertion macros used by the circular deque unit RTL.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Plain property check, sampled on clk and switched off while arst_n is low.
`define CDQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Implication check: whenever cond holds, prop must hold in the same cycle.
`define CDQ_ASSERT_IMP(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle check: whenever cond holds, prop must hold in the next cycle.
`define CDQ_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

FILE: design/cdq_pkg.sv
// ---------------------------------------------------------------------------
// cdq_pkg
// Types and constants of the circular deque unit.
// ---------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

	// Widths fixed by the request format.
	localparam int OP_W    = 3;
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;

	// Operation codes of one request.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_QUERY      = 3'd4
	} op_t;

	// Sequencer states: idle, memory read, result strobe.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RESP
	} state_t;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [COUNT_W-1:0]       count_t;

	// Value reported for front and rear while the deque is empty.
	localparam word_t EMPTY_WORD = -32'sd1;

endpackage

`default_nettype wire

FILE: design/cdq_ram.sv
// ---------------------------------------------------------------------------
// cdq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Two read ports; the data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

FILE: design/circular_deque_unit.sv
// ---------------------------------------------------------------------------
// circular_deque_unit
// Double-ended ring-buffer queue of signed 32-bit words held in a RAM.
// ---------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ------------------------------------------
//  request   start / busy           op, value
//  result    done (one-cycle pulse) ok, front_value, rear_value, entry_count,
//                                   is_empty, is_full
//  config    cfg_valid / cfg_ready  cfg_data (capacity)
//
//  Each request runs in steps: the accept edge updates the pointers and writes
//  a pushed word, the edge that leaves ST_READ reads front and rear from the
//  RAM, and in ST_RESP the result shows with done high. The registered read
//  of the entry RAM sets this order; busy stays high in ST_READ and ST_RESP.
//  While cfg_valid is high the idle block shows busy, so a capacity write
//  goes ahead of a request offered in the same cycle.
//  Reset sets pointers, count and capacity at once; the RAM is not cleared,
//  since no entry is read before it is written. The receiver cannot stall.
// ---------------------------------------------------------------------------
`default_nettype none

`include "circular_deque_unit_defines.svh"

module circular_deque_unit #(
	parameter int DEPTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Request channel.
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [2:0]             op,
	input  wire cdq_pkg::word_t         value,
	// Configuration channel.
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire cdq_pkg::count_t        cfg_data,
	// Result channel.
	output logic                        done,
	output logic                        ok,
	output cdq_pkg::word_t              front_value,
	output cdq_pkg::word_t              rear_value,
	output cdq_pkg::count_t             entry_count,
	output logic                        is_empty,
	output logic                        is_full
);

	import cdq_pkg::*;

	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam int CAP_RST = (DEPTH < 16) ? DEPTH : 16;

	state_t          state_q, state_d;
	count_t          capacity_q;
	logic [AW-1:0]   cap_last_q;
	logic [AW-1:0]   front_q, rear_q;
	count_t          count_q;
	logic            ok_q;

	logic            accept, cfg_accept;
	logic            has_room, has_entry;
	logic [AW-1:0]   front_dec, front_inc, rear_dec, rear_inc;
	logic [AW-1:0]   front_d, rear_d;
	count_t          count_d;
	logic            ok_d;
	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr;
	word_t           rd_front, rd_rear;
	count_t          cfg_cap;
	op_t             op_code;

	assign accept     = start && !busy;
	assign cfg_accept = cfg_valid && cfg_ready;

	// Capacity as written: zero becomes one, values above the store saturate.
	always_comb begin
		cfg_cap = cfg_data;
		if (cfg_data == '0) begin
			cfg_cap = COUNT_W'(1);
		end else if (cfg_data > COUNT_W'(CAP_MAX)) begin
			cfg_cap = COUNT_W'(CAP_MAX);
		end
	end

	// Pointer steps modulo the capacity in use.
	assign front_dec = (front_q == '0) ? cap_last_q : front_q - AW'(1);
	assign front_inc = (front_q == cap_last_q) ? '0 : front_q + AW'(1);
	assign rear_dec  = (rear_q == '0) ? cap_last_q : rear_q - AW'(1);
	assign rear_inc  = (rear_q == cap_last_q) ? '0 : rear_q + AW'(1);

	assign has_room  = count_q < capacity_q;
	assign has_entry = count_q != '0;
	assign op_code   = op_t'(op);

	// Decode of one request: next pointers, count, success and RAM write.
	always_comb begin
		front_d   = front_q;
		rear_d    = rear_q;
		count_d   = count_q;
		ok_d      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = front_dec;
		case (op_code)
			OP_PUSH_FRONT: begin
				if (has_room) begin
					front_d   = front_dec;
					count_d   = count_q + COUNT_W'(1);
					ok_d      = 1'b1;
					ram_we    = accept;
					ram_waddr = front_dec;
				end
			end
			OP_PUSH_REAR: begin
				if (has_room) begin
					rear_d    = rear_inc;
					count_d   = count_q + COUNT_W'(1);
					ok_d      = 1'b1;
					ram_we    = accept;
					ram_waddr = rear_inc;
				end
			end
			OP_POP_FRONT: begin
				if (has_entry) begin
					front_d = front_inc;
					count_d = count_q - COUNT_W'(1);
					ok_d    = 1'b1;
				end
			end
			OP_POP_REAR: begin
				if (has_entry) begin
					rear_d  = rear_dec;
					count_d = count_q - COUNT_W'(1);
					ok_d    = 1'b1;
				end
			end
			OP_QUERY: begin
				ok_d = 1'b1;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	// Deque control state; a capacity write empties the deque.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= COUNT_W'(CAP_RST);
			cap_last_q <= AW'(CAP_RST - 1);
			front_q    <= '0;
			rear_q     <= AW'(CAP_RST - 1);
			count_q    <= '0;
			ok_q       <= 1'b0;
		end else if (cfg_accept) begin
			capacity_q <= cfg_cap;
			cap_last_q <= AW'(COUNT_W'(cfg_cap - COUNT_W'(1)));
			front_q    <= '0;
			rear_q     <= AW'(COUNT_W'(cfg_cap - COUNT_W'(1)));
			count_q    <= '0;
		end else if (accept) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
			ok_q    <= ok_d;
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and controls.
	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		cfg_ready = 1'b0;
		ram_re    = 1'b0;
		done      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// A pending capacity write holds requests off for this cycle.
				busy      = cfg_valid;
				cfg_ready = 1'b1;
				if (start && !cfg_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Entry store.
	cdq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (ram_we && !cfg_valid),
		.waddr   (ram_waddr),
		.wdata   (value),
		.re      (ram_re),
		.raddr_a (front_q),
		.raddr_b (rear_q),
		.rdata_a (rd_front),
		.rdata_b (rd_rear)
	);

	// Result fields; empty deques report the empty marker.
	assign ok          = ok_q;
	assign entry_count = count_q;
	assign is_empty    = count_q == '0;
	assign is_full     = count_q >= capacity_q;
	assign front_value = is_empty ? EMPTY_WORD : rd_front;
	assign rear_value  = is_empty ? EMPTY_WORD : rd_rear;

	// Checks on count bounds, sequencing and state updates.
	`CDQ_ASSERT(a_count_bound, count_q <= capacity_q, "entry count above capacity")
	`CDQ_ASSERT_IMP(a_done_after_read, done, $past(state_q == ST_READ),
		"result strobe without a memory read")
	`CDQ_ASSERT_NEXT(a_accept_busy, start && !busy && !cfg_valid, busy && !done,
		"accepted request did not start a read")
	`CDQ_ASSERT_IMP(a_count_change, !$stable(count_q),
		$past(start && !busy) || $past(cfg_valid && cfg_ready),
		"entry count changed without a request or capacity write")

endmodule

`default_nettype wire
